>>> rtl/dltq_pkg.sv
// Package: sizes, codes, node layout and sequencer states of the timer queue.
`timescale 1ns / 1ps
`default_nettype none
package dltq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int DELTA_W     = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_TICK   = 2'd1;
  localparam logic [1:0] FN_FLUSH  = 2'd2;

  // Result codes
  localparam logic [1:0] EV_ACCEPTED = 2'd0;
  localparam logic [1:0] EV_FULL     = 2'd1;
  localparam logic [1:0] EV_WOKEN    = 2'd2;

  // One list node as stored in the node memory
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [DELTA_W-1:0] delta;
    logic [PTR_W-1:0]   link;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_ALLOC,
    ST_INS_WALK,
    ST_INS_WRITE,
    ST_INS_LINK,
    ST_POP,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/delta_list_timer_queue.sv
// Top level: delta-list timer queue built as a linked list in one node memory.
// Insert: result after states ALLOC, WALK (over the entries ahead of it), WRITE and, off the head, LINK.
// Tick/flush waking k waiters: k results, one per cycle, the final one marked last;
// a tick that wakes none gives no result. One request at a time; receiver cannot stall.
// A full-queue insert is answered the next cycle without going busy; an empty/no-op request gets no result.
// Synchronous active-low reset empties the queue at once; the node memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_waiter_id,
  input  wire logic [31:0] in_delay_ticks,
  output logic             out_valid,
  output logic [1:0]       out_event_res,
  output logic [7:0]       out_woken_id,
  output logic             out_last
);

  // Node memory: one write port, one registered read port
  node_t              mem [QUEUE_DEPTH];
  node_t              mem_rdata_r;
  logic [PTR_W-1:0]   mem_raddr;
  logic [PTR_W-1:0]   mem_waddr;
  node_t              mem_wdata;
  logic               mem_we;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   free_head_r, free_head_nxt;
  logic [CNT_W-1:0]   fresh_r, fresh_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   new_r, new_nxt;
  logic [PTR_W-1:0]   cur_r, cur_nxt;
  logic [PTR_W-1:0]   prev_r, prev_nxt;
  node_t              prev_node_r, prev_node_nxt;
  logic               prev_none_r, prev_none_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               first_r, first_nxt;
  logic               flush_r, flush_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [ID_BITS-1:0] pend_id_r, pend_id_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_event_r, out_event_nxt;
  logic [7:0]         out_woken_r, out_woken_nxt;
  logic               out_last_r, out_last_nxt;

  logic [DELTA_W-1:0] eff_delta;
  logic               head_due;

  // Memory access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Head delta after this tick's decrement (first node of a tick only)
  always_comb begin
    if (first_r && (mem_rdata_r.delta != '0)) begin
      eff_delta = mem_rdata_r.delta - DELTA_W'(1);
    end else begin
      eff_delta = mem_rdata_r.delta;
    end
    head_due = flush_r || (eff_delta == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fresh_r      <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fresh_r      <= fresh_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Pointers and payload registers
  always_ff @(posedge clk) begin
    head_r      <= head_nxt;
    free_head_r <= free_head_nxt;
    new_r       <= new_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_node_r <= prev_node_nxt;
    prev_none_r <= prev_none_nxt;
    rem_r       <= rem_nxt;
    k_r         <= k_nxt;
    id_r        <= id_nxt;
    first_r     <= first_nxt;
    flush_r     <= flush_nxt;
    pend_id_r   <= pend_id_nxt;
    out_event_r <= out_event_nxt;
    out_woken_r <= out_woken_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer: next state, memory accesses and results
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    new_nxt        = new_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_node_nxt  = prev_node_r;
    prev_none_nxt  = prev_none_r;
    rem_nxt        = rem_r;
    k_nxt          = k_r;
    id_nxt         = id_r;
    first_nxt      = first_r;
    flush_nxt      = flush_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = 1'b0;
    out_event_nxt  = out_event_r;
    out_woken_nxt  = out_woken_r;
    out_last_nxt   = out_last_r;
    mem_raddr      = head_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = mem_rdata_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_func)
            FN_INSERT: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_event_nxt = EV_FULL;
                out_woken_nxt = '0;
                out_last_nxt  = 1'b1;
              end else begin
                id_nxt        = in_waiter_id[ID_BITS-1:0];
                rem_nxt       = in_delay_ticks;
                k_nxt         = '0;
                prev_none_nxt = 1'b1;
                // fetch the free-list head in case no fresh node is left
                mem_raddr     = free_head_r;
                state_nxt     = ST_INS_ALLOC;
              end
            end
            FN_TICK, FN_FLUSH: begin
              if (count_r != '0) begin
                first_nxt      = 1'b1;
                flush_nxt      = (in_func == FN_FLUSH);
                pend_valid_nxt = 1'b0;
                mem_raddr      = head_r;
                state_nxt      = ST_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Allocate a node: never-used nodes first, then the free list
      ST_INS_ALLOC: begin
        if (fresh_r < CNT_W'(QUEUE_DEPTH)) begin
          new_nxt   = fresh_r[PTR_W-1:0];
          fresh_nxt = fresh_r + CNT_W'(1);
        end else begin
          new_nxt       = free_head_r;
          free_head_nxt = mem_rdata_r.link;
        end
        if (count_r == '0) begin
          state_nxt = ST_INS_WRITE;
        end else begin
          mem_raddr = head_r;
          cur_nxt   = head_r;
          state_nxt = ST_INS_WALK;
        end
      end

      // Walk one entry per cycle, subtracting deltas
      ST_INS_WALK: begin
        if (mem_rdata_r.delta > rem_r) begin
          mem_we          = 1'b1;
          mem_waddr       = cur_r;
          mem_wdata.delta = mem_rdata_r.delta - rem_r;
          state_nxt       = ST_INS_WRITE;
        end else begin
          rem_nxt       = rem_r - mem_rdata_r.delta;
          prev_nxt      = cur_r;
          prev_node_nxt = mem_rdata_r;
          prev_none_nxt = 1'b0;
          k_nxt         = k_r + CNT_W'(1);
          if (k_r + CNT_W'(1) == count_r) begin
            state_nxt = ST_INS_WRITE;
          end else begin
            cur_nxt   = mem_rdata_r.link;
            mem_raddr = mem_rdata_r.link;
          end
        end
      end

      // Write the new node; link it at the head or go patch its predecessor
      ST_INS_WRITE: begin
        mem_we          = 1'b1;
        mem_waddr       = new_r;
        mem_wdata.id    = id_r;
        mem_wdata.delta = rem_r;
        mem_wdata.link  = cur_r;
        if (prev_none_r) begin
          head_nxt      = new_r;
          count_nxt     = count_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_event_nxt = EV_ACCEPTED;
          out_woken_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_INS_LINK;
        end
      end

      ST_INS_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = prev_r;
        mem_wdata      = prev_node_r;
        mem_wdata.link = new_r;
        count_nxt      = count_r + CNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_event_nxt  = EV_ACCEPTED;
        out_woken_nxt  = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end

      // Pop due heads; each woken id is held until the next head shows whether it is last
      ST_POP: begin
        first_nxt = 1'b0;
        if (head_due) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_event_nxt = EV_WOKEN;
            out_woken_nxt = 8'(pend_id_r);
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = mem_rdata_r.id;
          if (!flush_r) begin
            // push the freed node on the free list
            mem_we         = 1'b1;
            mem_waddr      = head_r;
            mem_wdata.link = free_head_r;
            free_head_nxt  = head_r;
          end
          head_nxt  = mem_rdata_r.link;
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_DRAIN;
          end else begin
            mem_raddr = mem_rdata_r.link;
          end
        end else begin
          if (first_r && (mem_rdata_r.delta != '0)) begin
            mem_we          = 1'b1;
            mem_waddr       = head_r;
            mem_wdata.delta = eff_delta;
          end
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_event_nxt = EV_WOKEN;
            out_woken_nxt = 8'(pend_id_r);
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      // Emit the held waiter as the final result; a flush frees every node
      ST_DRAIN: begin
        out_valid_nxt  = 1'b1;
        out_event_nxt  = EV_WOKEN;
        out_woken_nxt  = 8'(pend_id_r);
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
        if (flush_r) begin
          fresh_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_woken_id  = out_woken_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS_WALK |-> k_r < count_r)
    else $error("insert walk past end of list");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> count_r != '0)
    else $error("pop from empty list");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EV_FULL) |-> $past(count_r) == CNT_W'(QUEUE_DEPTH))
    else $error("full reported with room left");
`endif

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the delta-list timer queue: directed and random requests.
`timescale 1ns / 1ps
module testbench;
  import dltq_pkg::*;

  localparam logic [1:0] FN_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         SETTLE_WAIT  = QUEUE_DEPTH + 8;
  localparam int         RANDOM_COUNT = 135;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  waiter;
    logic [31:0] delay;
    int unsigned idle_pct;
    bit          hold_for_drain;
  } request_t;

  typedef struct {
    logic [1:0] ev;
    logic [7:0] id;
    logic       last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_func = '0;
  logic [7:0]  in_waiter_id = '0;
  logic [31:0] in_delay_ticks = '0;
  logic        out_valid;
  logic [1:0]  out_event_res;
  logic [7:0]  out_woken_id;
  logic        out_last;

  // Sleeper list as the block should hold it
  logic [ID_BITS-1:0] sleep_ids[QUEUE_DEPTH];
  logic [31:0]        sleep_deltas[QUEUE_DEPTH];
  int                 sleep_count = 0;

  request_t request_q[$];
  answer_t  answer_q[$];
  request_t live_req;
  int       fail_count = 0;
  int       cycle_count = 0;

  delta_list_timer_queue i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_waiter_id   (in_waiter_id),
    .in_delay_ticks (in_delay_ticks),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_woken_id   (out_woken_id),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Emit the head sleeper as woken and shift the list down
  function automatic void wake_head();
    answer_t a;
    int      k;
    a.ev   = EV_WOKEN;
    a.id   = 8'(sleep_ids[0]);
    a.last = 1'b0;
    answer_q.push_back(a);
    for (k = 0; k < sleep_count - 1; k++) begin
      sleep_ids[k]    = sleep_ids[k + 1];
      sleep_deltas[k] = sleep_deltas[k + 1];
    end
    sleep_count--;
  endfunction

  // Update the sleeper list for one accepted request and queue its answers
  function automatic void apply_request(request_t r);
    logic [31:0] left;
    int          pos;
    int          k;
    int          woke;
    answer_t     a;
    left = r.delay;
    pos  = 0;
    woke = 0;
    case (r.func)
      FN_INSERT: begin
        a.id   = 8'd0;
        a.last = 1'b1;
        if (sleep_count >= QUEUE_DEPTH) begin
          a.ev = EV_FULL;
        end else begin
          // walk past every entry that wakes no later than the new one
          while (pos < sleep_count && sleep_deltas[pos] <= left) begin
            left -= sleep_deltas[pos];
            pos++;
          end
          if (pos < sleep_count) begin
            sleep_deltas[pos] -= left;
          end
          for (k = sleep_count; k > pos; k--) begin
            sleep_ids[k]    = sleep_ids[k - 1];
            sleep_deltas[k] = sleep_deltas[k - 1];
          end
          sleep_ids[pos]    = r.waiter[ID_BITS-1:0];
          sleep_deltas[pos] = left;
          sleep_count++;
          a.ev = EV_ACCEPTED;
        end
        answer_q.push_back(a);
      end
      FN_TICK: begin
        if (sleep_count != 0) begin
          if (sleep_deltas[0] != 0) begin
            sleep_deltas[0]--;
          end
          while (sleep_count > 0 && sleep_deltas[0] == 0) begin
            wake_head();
            woke++;
          end
        end
      end
      FN_FLUSH: begin
        while (sleep_count > 0) begin
          wake_head();
          woke++;
        end
      end
      default: begin
      end
    endcase
    if (woke > 0) begin
      answer_q[answer_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void queue_request(logic [1:0] func, logic [7:0] waiter,
                                        logic [31:0] delay, int unsigned idle_pct,
                                        bit hold_for_drain);
    request_t r;
    r.func           = func;
    r.waiter         = waiter;
    r.delay          = delay;
    r.idle_pct       = idle_pct;
    r.hold_for_drain = hold_for_drain;
    request_q.push_back(r);
  endfunction

  // Mostly short sleeps and ticks so that wakes happen often; some long and edge delays
  function automatic logic [31:0] random_delay();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 32'($urandom_range(0, 6));
    end else if (pick < 82) begin
      return 32'($urandom_range(0, 40));
    end else if (pick < 94) begin
      return 32'($urandom);
    end else if (pick < 97) begin
      return 32'hFFFF_FFFF;
    end
    return 32'd0;
  endfunction

  // Present requests; advance to the next one on acceptance or while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) begin
        apply_request(live_req);
      end
      if (request_q.size() != 0
          && !(request_q[0].hold_for_drain && answer_q.size() != 0)
          && $urandom_range(0, 99) >= request_q[0].idle_pct) begin
        live_req = request_q.pop_front();
        start          <= 1'b1;
        in_func        <= live_req.func;
        in_waiter_id   <= live_req.waiter;
        in_delay_ticks <= live_req.delay;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Compare each result strobe with the oldest pending answer
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result: event_res %0d woken_id %0d last %0d",
               out_event_res, out_woken_id, out_last);
        fail_count++;
      end else begin
        a = answer_q.pop_front();
        if (out_event_res !== a.ev) begin
          $error("event_res: expected %0d, got %0d", a.ev, out_event_res);
          fail_count++;
        end
        if (out_woken_id !== a.id) begin
          $error("woken_id: expected %0d, got %0d", a.id, out_woken_id);
          fail_count++;
        end
        if (out_last !== a.last) begin
          $error("last: expected %0d, got %0d", a.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          n;
    int          k;
    int unsigned idle;
    int unsigned pick;

    // Directed: empty queue, unused code, equal and zero delays, not-yet-due head
    queue_request(FN_TICK, 8'h00, 32'd0, 17, 1'b0);
    queue_request(FN_FLUSH, 8'h00, 32'd0, 17, 1'b0);
    queue_request(FN_UNUSED, 8'hA5, 32'h5A5A_A5A5, 17, 1'b0);
    queue_request(FN_INSERT, 8'h00, 32'd0, 17, 1'b0);
    queue_request(FN_INSERT, 8'hFF, 32'hFFFF_FFFF, 17, 1'b0);
    queue_request(FN_INSERT, 8'h11, 32'd1, 17, 1'b0);
    queue_request(FN_INSERT, 8'h22, 32'd1, 17, 1'b0);
    queue_request(FN_INSERT, 8'h33, 32'd0, 17, 1'b0);
    queue_request(FN_TICK, 8'h00, 32'd0, 17, 1'b0);
    queue_request(FN_TICK, 8'h00, 32'd0, 17, 1'b0);
    queue_request(FN_TICK, 8'h00, 32'd0, 17, 1'b0);
    // Fill the list, overflow it, then flush a full list
    for (k = 0; k < QUEUE_DEPTH - 1; k++) begin
      queue_request(FN_INSERT, 8'(8'h40 + k), 32'($urandom_range(0, 9)), 17, 1'b0);
    end
    queue_request(FN_INSERT, 8'h77, 32'd3, 17, 1'b0);
    queue_request(FN_FLUSH, 8'h00, 32'd0, 17, 1'b0);

    // Random: sender idle rate changes per phase, each phase starts from a drained block
    for (ph = 0; ph < 3; ph++) begin
      idle = (ph == 0) ? 17 : (ph == 1) ? 46 : 0;
      for (n = 0; n < RANDOM_COUNT; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          // burst of inserts to hit the full case
          for (k = 0; k <= QUEUE_DEPTH; k++) begin
            queue_request(FN_INSERT, 8'($urandom_range(0, 255)), random_delay(), idle,
                          1'b0);
          end
          n += QUEUE_DEPTH;
        end else begin
          pick = $urandom_range(0, 99);
          queue_request((pick < 52) ? FN_INSERT : (pick < 90) ? FN_TICK :
                        (pick < 96) ? FN_FLUSH : FN_UNUSED,
                        8'($urandom_range(0, 255)), random_delay(), idle,
                        (n == 0) || ($urandom_range(0, 99) < 2));
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests taken, all answers seen, then let the block settle
    while (request_q.size() != 0 || start) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
